@@ design/cbr_pkg.sv @@
`default_nettype none
package cbr_pkg;

  localparam int RANK_W  = 32;
  localparam int EXT_W   = 16;
  localparam int PARTS_W = 9;
  localparam int COORD_W = 8;
  localparam int COLOR_W = 24;
  localparam int VOL_W   = 64;
  localparam int NDIM    = 4;
  localparam int NLANE   = 2 * NDIM;
  localparam int NUM_W   = 24;

  typedef enum logic [2:0] {
    REG_DIMS   = 3'd0,
    REG_PARTS0 = 3'd1,
    REG_PARTS1 = 3'd2,
    REG_PARTS2 = 3'd3,
    REG_PARTS3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RANK_W-1:0] proc_rank;
    logic [EXT_W-1:0]  extent_dim0;
    logic [EXT_W-1:0]  extent_dim1;
    logic [EXT_W-1:0]  extent_dim2;
    logic [EXT_W-1:0]  extent_dim3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         dim_index;
    logic [EXT_W-1:0]   range_start;
    logic [EXT_W-1:0]   range_end;
    logic [EXT_W-1:0]   slice_length;
    logic [COORD_W-1:0] fiber_rank;
    logic [COLOR_W-1:0] fiber_color;
    logic [VOL_W-1:0]   block_volume;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]             w;
    logic [PARTS_W-1:0]            rem;
    logic [NDIM-1:0][COORD_W-1:0]  coord;
    logic [NDIM-1:0][EXT_W-1:0]    ext;
  } rad_t;

  typedef struct packed {
    logic [NDIM-1:0][COORD_W-1:0]  coord;
    logic [NLANE-1:0][EXT_W-1:0]   rw;
    logic [NLANE-1:0][PARTS_W-1:0] rr;
  } rng_t;

  typedef struct packed {
    logic [NDIM-1:0][EXT_W-1:0]    rs;
    logic [NDIM-1:0][EXT_W-1:0]    re;
    logic [NDIM-1:0][EXT_W-1:0]    len;
    logic [NDIM-1:0][EXT_W-1:0]    lv;
    logic [NDIM-1:0][COORD_W-1:0]  coord;
    logic [NDIM-1:0][COLOR_W-1:0]  color;
    logic [2*EXT_W-1:0]            p01;
    logic [2*EXT_W-1:0]            p23;
    logic [VOL_W-1:0]              vol;
  } fin_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [PARTS_W:0] div_step(input logic [PARTS_W-1:0] rem,
                                                input logic bin,
                                                input logic [PARTS_W-1:0] den);
    logic [PARTS_W:0]   t;
    logic               ge;
    logic [PARTS_W-1:0] r;
    t  = {rem, bin};
    ge = (t >= {1'b0, den});
    r  = ge ? PARTS_W'(t - {1'b0, den}) : t[PARTS_W-1:0];
    return {ge, r};
  endfunction

endpackage
`default_nettype wire

@@ design/cartesian_block_range_calc.sv @@
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------
// in       | start, busy               | in_data (in_item_t)
// out      | out_strobe (no stall)     | out_data (out_item_t)
// cfg      | cfg_valid, cfg_ready (=1) | cfg_index, cfg_data
//
// busy stays high after a request is taken until its effective dims (1..MAX_DIMS) count down:
// busy holds off the next request so that its beats follow the previous item's beats on out.
// First beat follows the request through the divide chains; one beat per
// cycle after that. The latency is set mostly by the chain of divide cells: 32 per
// grid dimension for the rank split, 16 for the slice bounds.
// Synchronous active-low reset clears valids and counters and sets config registers to dims 4, parts 1.
`default_nettype none
module cartesian_block_range_calc import cbr_pkg::*; #(
  parameter int MAX_DIMS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  in_item_t     in_data,
  output logic         out_strobe,
  output out_item_t    out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [8:0]   cfg_data
);

  localparam int NRAD = RANK_W * MAX_DIMS;
  localparam int NRNG = EXT_W;

  logic [2:0]                   dims_r;
  logic [NDIM-1:0][PARTS_W-1:0] parts_r;
  logic [NDIM-1:0][PARTS_W-1:0] parts_e;
  logic [2:0]                   nd;
  logic                         accept;
  logic [1:0]                   cnt_r, cnt_nxt;

  logic rad_vld [NRAD+1];
  rad_t rad_q   [NRAD+1];
  logic rad0_vld_r;
  rad_t rad0_r;

  logic rng_vld [NRNG+1];
  rng_t rng_q   [NRNG+1];
  logic rng0_vld_r;
  rng_t rng0_r, rng0_nxt;

  logic fin_vld;
  fin_t fin_q;

  logic       hold_vld_r;
  logic [1:0] k_r;
  fin_t       hold_r;
  logic       is_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= 3'd4;
      parts_r <= {NDIM{9'd1}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIMS:   dims_r     <= cfg_data[2:0];
        REG_PARTS0: parts_r[0] <= cfg_data;
        REG_PARTS1: parts_r[1] <= cfg_data;
        REG_PARTS2: parts_r[2] <= cfg_data;
        REG_PARTS3: parts_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      if (parts_r[d] == '0) begin
        parts_e[d] = 9'd1;
      end else if (parts_r[d] > 9'd256) begin
        parts_e[d] = 9'd256;
      end else begin
        parts_e[d] = parts_r[d];
      end
    end
    if (dims_r == '0) begin
      nd = 3'd1;
    end else if (dims_r > 3'(MAX_DIMS)) begin
      nd = 3'(MAX_DIMS);
    end else begin
      nd = dims_r;
    end
  end

  assign busy   = (cnt_r != '0);
  assign accept = start && !busy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = 2'(nd - 3'd1);
    end else if (busy) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rad0_vld_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      rad0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rad0_r.w      <= in_data.proc_rank;
    rad0_r.rem    <= '0;
    rad0_r.coord  <= '0;
    rad0_r.ext[0] <= in_data.extent_dim0;
    rad0_r.ext[1] <= in_data.extent_dim1;
    rad0_r.ext[2] <= in_data.extent_dim2;
    rad0_r.ext[3] <= in_data.extent_dim3;
  end

  assign rad_vld[0] = rad0_vld_r;
  assign rad_q[0]   = rad0_r;

  for (genvar gd = 0; gd < MAX_DIMS; gd++) begin : g_dim
    for (genvar gb = 0; gb < RANK_W; gb++) begin : g_bit
      localparam int IDX = gd * RANK_W + gb;
      cbr_radix_cell #(
        .DIM  (gd),
        .LAST (gb == RANK_W - 1)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .den     (parts_e[gd]),
        .nd      (nd),
        .in_vld  (rad_vld[IDX]),
        .in_q    (rad_q[IDX]),
        .out_vld (rad_vld[IDX+1]),
        .out_q   (rad_q[IDX+1])
      );
    end
  end

  // numerators ext*coord + parts-1 and ext*(coord+1) + parts-1
  always_comb begin
    logic [NUM_W:0] num;
    rng0_nxt       = '0;
    rng0_nxt.coord = rad_q[NRAD].coord;
    for (int j = 0; j < NLANE; j++) begin
      num = (NUM_W+1)'(rad_q[NRAD].ext[j/2])
          * (NUM_W+1)'(9'(rad_q[NRAD].coord[j/2]) + 9'(j % 2))
          + (NUM_W+1)'(parts_e[j/2] - 9'd1);
      rng0_nxt.rw[j] = num[EXT_W-1:0];
      rng0_nxt.rr[j] = {1'b0, num[NUM_W-1:EXT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng0_vld_r <= 1'b0;
    end else begin
      rng0_vld_r <= rad_vld[NRAD];
    end
  end

  always_ff @(posedge clk) begin
    rng0_r <= rng0_nxt;
  end

  assign rng_vld[0] = rng0_vld_r;
  assign rng_q[0]   = rng0_r;

  for (genvar gr = 0; gr < NRNG; gr++) begin : g_rng
    cbr_range_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .parts   (parts_e),
      .in_vld  (rng_vld[gr]),
      .in_q    (rng_q[gr]),
      .out_vld (rng_vld[gr+1]),
      .out_q   (rng_q[gr+1])
    );
  end

  cbr_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .parts   (parts_e),
    .nd      (nd),
    .in_vld  (rng_vld[NRNG]),
    .in_q    (rng_q[NRNG]),
    .out_vld (fin_vld),
    .out_q   (fin_q)
  );

  assign is_last = (k_r == 2'(nd - 3'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      k_r        <= '0;
    end else if (fin_vld) begin
      hold_vld_r <= 1'b1;
      k_r        <= '0;
    end else if (hold_vld_r) begin
      if (is_last) begin
        hold_vld_r <= 1'b0;
      end
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_vld) begin
      hold_r <= fin_q;
    end
  end

  assign out_strobe = hold_vld_r;

  always_comb begin
    out_data.dim_index    = k_r;
    out_data.range_start  = hold_r.rs[k_r];
    out_data.range_end    = hold_r.re[k_r];
    out_data.slice_length = hold_r.len[k_r];
    out_data.fiber_rank   = hold_r.coord[k_r];
    out_data.fiber_color  = hold_r.color[k_r];
    out_data.block_volume = is_last ? hold_r.vol : '0;
    out_data.last         = is_last;
  end

endmodule
`default_nettype wire

@@ design/cbr_radix_cell.sv @@
`default_nettype none
module cbr_radix_cell import cbr_pkg::*; #(
  parameter int DIM  = 0,
  parameter bit LAST = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [PARTS_W-1:0] den,
  input  logic [2:0]         nd,
  input  logic               in_vld,
  input  rad_t               in_q,
  output logic               out_vld,
  output rad_t               out_q
);

  logic           vld_r;
  rad_t           q_r, q_nxt;
  logic [PARTS_W:0] st;

  always_comb begin
    st      = div_step(in_q.rem, in_q.w[RANK_W-1], den);
    q_nxt   = in_q;
    q_nxt.w = {in_q.w[RANK_W-2:0], st[PARTS_W]};
    q_nxt.rem = st[PARTS_W-1:0];
    if (LAST) begin
      q_nxt.rem        = '0;
      q_nxt.coord[DIM] = (3'(DIM) < nd) ? st[COORD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_vld = vld_r;
  assign out_q   = q_r;

endmodule
`default_nettype wire

@@ design/cbr_range_cell.sv @@
`default_nettype none
module cbr_range_cell import cbr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [NDIM-1:0][PARTS_W-1:0] parts,
  input  logic                         in_vld,
  input  rng_t                         in_q,
  output logic                         out_vld,
  output rng_t                         out_q
);

  logic vld_r;
  rng_t q_r, q_nxt;

  always_comb begin
    logic [PARTS_W:0] st;
    q_nxt = in_q;
    for (int j = 0; j < NLANE; j++) begin
      st          = div_step(in_q.rr[j], in_q.rw[j][EXT_W-1], parts[j/2]);
      q_nxt.rw[j] = {in_q.rw[j][EXT_W-2:0], st[PARTS_W]};
      q_nxt.rr[j] = st[PARTS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_vld = vld_r;
  assign out_q   = q_r;

endmodule
`default_nettype wire

@@ design/cbr_finish.sv @@
`default_nettype none
module cbr_finish import cbr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [NDIM-1:0][PARTS_W-1:0] parts,
  input  logic [2:0]                   nd,
  input  logic                         in_vld,
  input  rng_t                         in_q,
  output logic                         out_vld,
  output fin_t                         out_q
);

  logic [NDIM:0] vld_r;
  fin_t          q_r [NDIM+1];
  fin_t          a_nxt;

  always_comb begin
    a_nxt = '0;
    for (int d = 0; d < NDIM; d++) begin
      a_nxt.rs[d]    = in_q.rw[2*d];
      a_nxt.re[d]    = in_q.rw[2*d+1];
      a_nxt.len[d]   = in_q.rw[2*d+1] - in_q.rw[2*d];
      a_nxt.lv[d]    = (3'(d) < nd) ? a_nxt.len[d] : EXT_W'(1);
      a_nxt.coord[d] = in_q.coord[d];
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= a_nxt;
  end

  // Horner over the other coordinates, top dimension first
  for (genvar s = 0; s < NDIM; s++) begin : g_stage
    localparam int DD = NDIM - 1 - s;
    fin_t s_nxt;
    always_comb begin
      s_nxt = q_r[s];
      for (int i = 0; i < NDIM; i++) begin
        if (DD != i && 3'(DD) < nd) begin
          s_nxt.color[i] = COLOR_W'(q_r[s].color[i] * parts[DD])
                         + COLOR_W'(q_r[s].coord[DD]);
        end
      end
      if (s == 0) begin
        s_nxt.p01 = {{EXT_W{1'b0}}, q_r[s].lv[0]} * {{EXT_W{1'b0}}, q_r[s].lv[1]};
        s_nxt.p23 = {{EXT_W{1'b0}}, q_r[s].lv[2]} * {{EXT_W{1'b0}}, q_r[s].lv[3]};
      end
      if (s == 1) begin
        s_nxt.vol = VOL_W'(q_r[s].p01) * VOL_W'(q_r[s].p23);
      end
    end
    always_ff @(posedge clk) begin
      q_r[s+1] <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NDIM-1:0], in_vld};
    end
  end

  assign out_vld = vld_r[NDIM];
  assign out_q   = q_r[NDIM];

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import cbr_pkg::*;

  localparam int DRAIN_CYCLES = 32 * NDIM + 24 + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [2:0] REG_UNUSED_LO = 3'(REG_PARTS3) + 3'd1;
  localparam logic [2:0] REG_UNUSED_HI = 3'(REG_PARTS3) + 3'd3;

  class range_scoreboard;
    logic [2:0]         dims_reg;
    logic [PARTS_W-1:0] parts_reg [NDIM];
    out_item_t          slices_q [$];
    int                 mismatches;

    function new();
      dims_reg = 3'd4;
      foreach (parts_reg[i]) parts_reg[i] = 1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] val);
      case (idx)
        REG_DIMS:   dims_reg = val[2:0];
        REG_PARTS0: parts_reg[0] = val;
        REG_PARTS1: parts_reg[1] = val;
        REG_PARTS2: parts_reg[2] = val;
        REG_PARTS3: parts_reg[3] = val;
        default: ;
      endcase
    endfunction

    function void note_request(in_item_t req);
      int unsigned nd, rank, ext, lo, hi, color, pre;
      int unsigned parts [NDIM];
      int unsigned coord [NDIM];
      logic [63:0] vol;
      out_item_t   beat;
      nd = dims_reg;
      if (nd == 0) nd = 1;
      if (nd > NDIM) nd = NDIM;
      rank = req.proc_rank;
      vol = 64'd1;
      for (int i = 0; i < NDIM; i++) begin
        parts[i] = parts_reg[i];
        if (parts[i] == 0) parts[i] = 1;
        if (parts[i] > 256) parts[i] = 256;
        coord[i] = 0;
      end
      for (int i = 0; i < nd; i++) begin
        coord[i] = rank % parts[i];
        rank = rank / parts[i];
      end
      for (int i = 0; i < nd; i++) begin
        case (i)
          0: ext = req.extent_dim0;
          1: ext = req.extent_dim1;
          2: ext = req.extent_dim2;
          default: ext = req.extent_dim3;
        endcase
        lo = (ext * coord[i] + parts[i] - 1) / parts[i];
        hi = (ext * (coord[i] + 1) + parts[i] - 1) / parts[i];
        color = 0;
        pre = 1;
        for (int d = 0; d < nd; d++) begin
          if (d != i) begin
            color += coord[d] * pre;
            pre *= parts[d];
          end
        end
        vol = vol * 64'(hi - lo);
        beat.dim_index    = 2'(i);
        beat.range_start  = 16'(lo);
        beat.range_end    = 16'(hi);
        beat.slice_length = 16'(hi - lo);
        beat.fiber_rank   = 8'(coord[i]);
        beat.fiber_color  = 24'(color);
        beat.last         = (i + 1 == nd);
        beat.block_volume = beat.last ? vol : 64'd0;
        slices_q = {slices_q, beat};
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (slices_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", got);
        return;
      end
      want = slices_q.pop_front();
      if (got.dim_index !== want.dim_index || got.range_start !== want.range_start ||
          got.range_end !== want.range_end || got.slice_length !== want.slice_length ||
          got.fiber_rank !== want.fiber_rank || got.fiber_color !== want.fiber_color ||
          got.block_volume !== want.block_volume || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: exp %p act %p", want, got);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_data = '0;
  logic       out_strobe;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  range_scoreboard sb;
  int cycles = 0;
  bit gaps_on;
  int unsigned grid_size;

  cartesian_block_range_calc dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cartesian_block_range_calc verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_strobe) sb.check_beat(out_data);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [8:0] nd, logic [8:0] p0, logic [8:0] p1,
                          logic [8:0] p2, logic [8:0] p3);
    int unsigned e;
    write_cfg(REG_DIMS, nd);
    write_cfg(REG_PARTS0, p0);
    write_cfg(REG_PARTS1, p1);
    write_cfg(REG_PARTS2, p2);
    write_cfg(REG_PARTS3, p3);
    grid_size = 1;
    foreach (sb.parts_reg[i]) begin
      e = sb.parts_reg[i];
      if (e == 0) e = 1;
      if (e > 256) e = 256;
      grid_size *= e;
    end
  endtask

  task automatic send_request(in_item_t req);
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.slices_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_extent();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic random_burst(int n);
    in_item_t req;
    repeat (n) begin
      req.proc_rank = ($urandom_range(0, 1) == 0) ? $urandom_range(0, grid_size - 1)
                                                  : $urandom;
      req.extent_dim0 = rand_extent();
      req.extent_dim1 = rand_extent();
      req.extent_dim2 = rand_extent();
      req.extent_dim3 = rand_extent();
      send_request(req);
    end
    drain();
  endtask

  initial begin
    sb = new();
    gaps_on = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid: one process, all four dims
    send_request('{32'd0, 16'd1, 16'hFFFF, 16'd0, 16'd7});
    send_request('{32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();

    set_grid(9'd4, 9'd3, 9'd5, 9'd7, 9'd256);
    send_request('{32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_request('{32'd26879, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF});
    send_request('{32'd26880, 16'd10, 16'd11, 16'd12, 16'd13});
    send_request('{32'hFFFFFFFF, 16'd1, 16'd2, 16'd3, 16'd4});
    send_request('{32'hAAAAAAAA, 16'h5555, 16'hAAAA, 16'h8000, 16'h0001});
    drain();

    // zero and oversized part counts, zero dims
    set_grid(9'd0, 9'd0, 9'h1FF, 9'd2, 9'd2);
    send_request('{32'd300, 16'd100, 16'd100, 16'd100, 16'd100});
    send_request('{32'h55555555, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();

    // too many dims, unknown indexes ignored
    set_grid(9'h1FF, 9'h1FF, 9'd256, 9'd1, 9'd255);
    write_cfg(REG_UNUSED_LO, 9'h1FF);
    write_cfg(REG_UNUSED_HI, 9'd0);
    send_request('{32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_request('{32'h12345678, 16'd0, 16'd3, 16'd255, 16'd256});
    drain();

    set_grid(9'd2, 9'd16, 9'd16, 9'd3, 9'd3);
    send_request('{32'd255, 16'd17, 16'd33, 16'd9, 16'd9});
    send_request('{32'd17, 16'd1, 16'd0, 16'd9, 16'd9});
    drain();

    set_grid(9'd3, 9'd1, 9'd256, 9'd256, 9'd4);
    send_request('{32'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        gaps_on = 1'b0;
        set_grid(9'd4, 9'd256, 9'd256, 9'd256, 9'd256);
      end else begin
        set_grid(9'($urandom_range(0, 7)),
                 ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12)),
                 ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12)),
                 ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12)),
                 ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(1, 12)));
      end
      random_burst(35);
    end

    if (sb.mismatches == 0 && sb.slices_q.size() == 0)
      $display("cartesian_block_range_calc verification clean");
    else
      $display("cartesian_block_range_calc verification failed");
    $finish;
  end

endmodule
